>>> design/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg: shared definitions for the Laplacian sharpening filter
// Field widths, register reset values, register indexes and the structs
// that travel between the filter's submodules.
// ----------------------------------------------------------------------------
`default_nettype none

package lss_pkg;

   // Default line store depth (largest frame width supported).
   localparam int DEF_MAX_WIDTH = 1024;

   // Field widths.
   localparam int PIX_W  = 8;
   localparam int ROW_W  = 12;
   localparam int COL_W  = 10;
   localparam int VAL_W  = 12;
   localparam int FW_W   = 11;
   localparam int FH_W   = 12;
   localparam int CSR_D_W = 12;
   localparam int CSR_I_W = 1;

   // Register reset values.
   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = FW_W'(64);
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = FH_W'(64);

   // Register indexes on the configuration port.
   typedef enum logic [CSR_I_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } lss_csr_index_type;

   // One result beat.
   typedef struct packed {
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        col;
      logic signed [VAL_W-1:0] value;
      logic                    is_border;
      logic                    last;
   } lss_result_type;

   // Position and classification of the pixel held in the input stage.
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             border;
      logic             inner;
   } lss_pos_type;

endpackage

`default_nettype wire

>>> design/laplacian_sharpen_3x3.sv
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3: streaming 3x3 Laplacian sharpening filter
// Raster pixel stream in, coordinate-tagged border and sharpened pixels out.
// ----------------------------------------------------------------------------
// The filter takes one pixel per clock while its output buffer has room. A
// pixel is held in the input stage while the line store read for its column
// completes. Its results are loaded into the output buffer registers once
// the buffer has room, and are offered from there. Border pixels come out
// unchanged; the arrival of pixel (r,c) with r and c at least 2 also yields
// the sharpened pixel (r-1,c-1), after the border beat when both occur. The
// output port moves one beat per cycle while rsp_ready is high, so a pixel
// with two results holds the input back while its first beat leaves, and a
// pixel with no result passes through the input stage like any other. The
// line store (one read and one write per cycle) has no clearing pass and is
// valid as soon as the rows above are written. Frame size registers may be
// written only while the filter is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module laplacian_sharpen_3x3 #(
   parameter int MAX_WIDTH = lss_pkg::DEF_MAX_WIDTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Configuration port
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [lss_pkg::CSR_I_W-1:0]       csr_index,
   input  wire logic [lss_pkg::CSR_D_W-1:0]       csr_data,
   // Pixel input
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [lss_pkg::PIX_W-1:0]         req_pixel,
   // Result output
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [lss_pkg::ROW_W-1:0]         rsp_out_row,
   output logic      [lss_pkg::COL_W-1:0]         rsp_out_col,
   output logic signed [lss_pkg::VAL_W-1:0]       rsp_out_value,
   output logic                                   rsp_is_border,
   output logic                                   rsp_last
);
   import lss_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   logic [FW_W-1:0]      frame_width_ff;
   logic [FH_W-1:0]      frame_height_ff;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 accept;
   logic                 s1_go;
   logic                 buf_free;
   logic [CW-1:0]        rd_addr;
   logic [CW-1:0]        wr_addr;
   lss_pos_type          pos;
   logic [2*PIX_W-1:0]   store_rd_data;
   logic [2*PIX_W-1:0]   store_wr_data;
   lss_result_type       brd_result;
   lss_result_type       int_result;
   lss_result_type       out_result;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (lss_csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[FW_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[FH_W-1:0];
            default: ;
         endcase
      end
   end

   // Input stage handshake: a held pixel moves on when the output has room.
   assign s1_go     = s1_valid_ff && buf_free;
   assign req_ready = !s1_valid_ff || s1_go;
   assign accept    = req_valid && req_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   lss_position #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_position (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .rd_addr      (rd_addr),
      .wr_addr      (wr_addr),
      .pos          (pos)
   );

   lss_line_store #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (2 * PIX_W)
   ) u_line_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (s1_go),
      .wr_addr (wr_addr),
      .wr_data (store_wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (store_rd_data)
   );

   lss_kernel u_kernel (
      .clock         (clock),
      .reset         (reset),
      .load          (accept),
      .advance       (s1_go),
      .pixel         (req_pixel),
      .pos           (pos),
      .store_data    (store_rd_data),
      .store_wr_data (store_wr_data),
      .brd_result    (brd_result),
      .int_result    (int_result)
   );

   lss_out_buffer u_out_buffer (
      .clock      (clock),
      .reset      (reset),
      .load       (s1_go),
      .brd_valid  (pos.border),
      .int_valid  (pos.inner),
      .brd_result (brd_result),
      .int_result (int_result),
      .out_ready  (rsp_ready),
      .out_valid  (rsp_valid),
      .out_result (out_result),
      .free       (buf_free)
   );

   assign rsp_out_row   = out_result.row;
   assign rsp_out_col   = out_result.col;
   assign rsp_out_value = out_result.value;
   assign rsp_is_border = out_result.is_border;
   assign rsp_last      = out_result.last;

endmodule

`default_nettype wire

>>> design/lss_line_store.sv
// ----------------------------------------------------------------------------
// lss_line_store: two-row line buffer memory
// One write and one registered read per cycle. A read issued in the same
// cycle as a write to the same address returns the new data.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_line_store #(
   parameter int DEPTH  = lss_pkg::DEF_MAX_WIDTH,
   parameter int DATA_W = 2 * lss_pkg::PIX_W
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire logic [DATA_W-1:0]         wr_data,
   input  wire logic                      rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic      [DATA_W-1:0]         rd_data
);
   import lss_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;
   logic [DATA_W-1:0] byp_data_ff;
   logic              byp_ff;
   logic              byp_in;

   // Memory write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Memory read port with registered data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         byp_data_ff <= wr_data;
      end
   end

   // Read-during-write to the same address takes the data being written.
   assign byp_in = rd_en ? (wr_en && (wr_addr == rd_addr)) : byp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= byp_in;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_data_ff;

endmodule

`default_nettype wire

>>> design/lss_position.sv
// ----------------------------------------------------------------------------
// lss_position: raster position tracking
// Keeps the row and column of the next pixel, wraps them at the frame edges
// and classifies each accepted pixel as border and/or window-complete.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_position #(
   parameter int MAX_WIDTH = lss_pkg::DEF_MAX_WIDTH
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire logic [lss_pkg::FW_W-1:0]       frame_width,
   input  wire logic [lss_pkg::FH_W-1:0]       frame_height,
   output logic      [$clog2(MAX_WIDTH)-1:0]   rd_addr,
   output logic      [$clog2(MAX_WIDTH)-1:0]   wr_addr,
   output lss_pkg::lss_pos_type                pos
);
   import lss_pkg::*;

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int EW  = ((WW > FW_W) ? WW : FW_W) + 1;

   logic [CW-1:0]    col_count_ff, col_count_in;
   logic [ROW_W-1:0] row_count_ff, row_count_in;
   logic [CW-1:0]    wr_addr_ff;
   lss_pos_type      pos_ff, pos_in;

   logic [EW-1:0]    eff_w;
   logic [FH_W-1:0]  eff_h;
   logic [CW-1:0]    cur_col;
   logic [ROW_W-1:0] cur_row;
   logic [ROW_W-1:0] row_step;
   logic [EW-1:0]    col_plus;
   logic [ROW_W-1:0] row_plus;

   // Effective frame size: zero acts as one, width limited to the store depth.
   always_comb begin
      eff_w = EW'(frame_width);
      if (frame_width == '0) begin
         eff_w = EW'(1);
      end else if (EW'(frame_width) > EW'(MAX_WIDTH)) begin
         eff_w = EW'(MAX_WIDTH);
      end
      eff_h = (frame_height == '0) ? FH_W'(1) : frame_height;
   end

   // Position of the arriving pixel after any wrap from a smaller frame.
   always_comb begin
      cur_col  = col_count_ff;
      row_step = row_count_ff;
      if (EW'(col_count_ff) >= eff_w) begin
         cur_col  = '0;
         row_step = row_count_ff + ROW_W'(1);
      end
      cur_row = (row_step >= eff_h) ? '0 : row_step;
   end

   // Position of the pixel after this one.
   always_comb begin
      col_plus     = EW'(cur_col) + EW'(1);
      row_plus     = cur_row + ROW_W'(1);
      col_count_in = CW'(col_plus);
      row_count_in = cur_row;
      if (col_plus >= eff_w) begin
         col_count_in = '0;
         row_count_in = (row_plus >= eff_h) ? '0 : row_plus;
      end
   end

   // Classification of the arriving pixel.
   always_comb begin
      pos_in.row    = cur_row;
      pos_in.col    = COL_W'(cur_col);
      pos_in.border = (cur_row == '0) || (cur_col == '0)
                      || (cur_row == eff_h - FH_W'(1))
                      || (EW'(cur_col) == eff_w - EW'(1));
      pos_in.inner  = (cur_row >= ROW_W'(2)) && (cur_col >= CW'(2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else if (accept) begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

   // Input stage position registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         pos_ff     <= pos_in;
         wr_addr_ff <= cur_col;
      end
   end

   assign rd_addr = cur_col;
   assign wr_addr = wr_addr_ff;
   assign pos     = pos_ff;

endmodule

`default_nettype wire

>>> design/lss_kernel.sv
// ----------------------------------------------------------------------------
// lss_kernel: 3x3 window and sharpening arithmetic
// Holds the input pixel and the two previous window columns, and forms the
// border pass-through and the interior sharpened result.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_kernel (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire logic                          advance,
   input  wire logic [lss_pkg::PIX_W-1:0]     pixel,
   input  wire lss_pkg::lss_pos_type          pos,
   input  wire logic [2*lss_pkg::PIX_W-1:0]   store_data,
   output logic      [2*lss_pkg::PIX_W-1:0]   store_wr_data,
   output lss_pkg::lss_result_type            brd_result,
   output lss_pkg::lss_result_type            int_result
);
   import lss_pkg::*;

   localparam int SUM_W = PIX_W + 3;
   localparam int LAP_W = SUM_W + 2;

   logic [PIX_W-1:0]        pixel_ff;
   logic [PIX_W-1:0]        win_ff [6];
   logic [PIX_W-1:0]        top;
   logic [PIX_W-1:0]        mid;
   logic [PIX_W-1:0]        center;
   logic [SUM_W-1:0]        sum;
   logic signed [LAP_W-1:0] lap;
   logic signed [LAP_W-1:0] half;
   logic signed [LAP_W-1:0] val;

   // Input stage pixel register.
   always_ff @(posedge clock) begin
      if (load) begin
         pixel_ff <= pixel;
      end
   end

   assign top    = store_data[2*PIX_W-1:PIX_W];
   assign mid    = store_data[PIX_W-1:0];
   assign center = win_ff[4];

   // Window shift: columns c-2 and c-1 of rows r-2 through r.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (advance) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top;
         win_ff[4] <= mid;
         win_ff[5] <= pixel_ff;
      end
   end

   // Sharpened value: center minus half the Laplacian, halved toward zero.
   always_comb begin
      sum  = SUM_W'(win_ff[0]) + SUM_W'(win_ff[1]) + SUM_W'(win_ff[2])
           + SUM_W'(win_ff[3]) + SUM_W'(win_ff[5])
           + SUM_W'(top) + SUM_W'(mid) + SUM_W'(pixel_ff);
      lap  = $signed({2'b00, sum}) - $signed({2'b00, center, 3'b000});
      half = (lap + $signed({{(LAP_W-1){1'b0}}, lap[LAP_W-1]})) >>> 1;
      val  = $signed(LAP_W'(center)) - half;
   end

   // Result beats.
   always_comb begin
      brd_result.row       = pos.row;
      brd_result.col       = pos.col;
      brd_result.value     = $signed(VAL_W'(pixel_ff));
      brd_result.is_border = 1'b1;
      brd_result.last      = !pos.inner;

      int_result.row       = pos.row - ROW_W'(1);
      int_result.col       = pos.col - COL_W'(1);
      int_result.value     = val[VAL_W-1:0];
      int_result.is_border = 1'b0;
      int_result.last      = 1'b1;
   end

   // Row r-1 moves to the older store half, row r to the newer one.
   assign store_wr_data = {mid, pixel_ff};

endmodule

`default_nettype wire

>>> design/lss_out_buffer.sv
// ----------------------------------------------------------------------------
// lss_out_buffer: result holding stage
// Holds the up to two results of one pixel and hands them out one beat at a
// time, border result first.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_out_buffer (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     load,
   input  wire logic                     brd_valid,
   input  wire logic                     int_valid,
   input  wire lss_pkg::lss_result_type  brd_result,
   input  wire lss_pkg::lss_result_type  int_result,
   input  wire logic                     out_ready,
   output logic                          out_valid,
   output lss_pkg::lss_result_type       out_result,
   output logic                          free
);
   import lss_pkg::*;

   logic           brd_pend_ff, brd_pend_in;
   logic           int_pend_ff, int_pend_in;
   lss_result_type brd_ff;
   lss_result_type int_ff;
   logic           take;

   assign out_valid  = brd_pend_ff || int_pend_ff;
   assign out_result = brd_pend_ff ? brd_ff : int_ff;
   assign take       = out_valid && out_ready;

   // Room for a new pixel's results once at most the beat leaving now remains.
   assign free = !out_valid || ((brd_pend_ff ^ int_pend_ff) && out_ready);

   // Pending flags.
   always_comb begin
      brd_pend_in = brd_pend_ff;
      int_pend_in = int_pend_ff;
      if (load) begin
         brd_pend_in = brd_valid;
         int_pend_in = int_valid;
      end else if (take) begin
         if (brd_pend_ff) begin
            brd_pend_in = 1'b0;
         end else begin
            int_pend_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brd_pend_ff <= 1'b0;
         int_pend_ff <= 1'b0;
      end else begin
         brd_pend_ff <= brd_pend_in;
         int_pend_ff <= int_pend_in;
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      if (load) begin
         brd_ff <= brd_result;
         int_ff <= int_result;
      end
   end

endmodule

`default_nettype wire

>>> tb/laplacian_sharpen_3x3_tb.sv
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_tb: self-checking bench for the sharpening filter
// Streams pixel frames of many sizes through the filter, predicts every
// border and sharpened beat in order, and compares each result beat field by
// field. Covers reset sizes, the start of the widest and tallest frames, tiny
// frames, value extremes, size changes in the middle of a frame, a long output
// stall and random frames with random idling on both sides.
// ----------------------------------------------------------------------------

module laplacian_sharpen_3x3_tb;

   import lss_pkg::*;

   localparam int LIMIT_CYCLES   = 1_000_000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 10;
   localparam int LONG_HOLD      = 300;
   localparam int REPORT_LIMIT   = 10;

   // Clock, reset and block inputs, all known from time zero.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic [CSR_I_W-1:0] csr_index = '0;
   logic [CSR_D_W-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic [PIX_W-1:0] req_pixel = '0;
   logic rsp_ready = 1'b0;

   logic csr_ready;
   logic req_ready;
   logic rsp_valid;
   logic [ROW_W-1:0] rsp_out_row;
   logic [COL_W-1:0] rsp_out_col;
   logic signed [VAL_W-1:0] rsp_out_value;
   logic rsp_is_border;
   logic rsp_last;

   // Predicted filter state: size registers, two line stores, window, position.
   int unsigned cfg_width = 64;
   int unsigned cfg_height = 64;
   logic [PIX_W-1:0] store_one_up [DEF_MAX_WIDTH];
   logic [PIX_W-1:0] store_two_up [DEF_MAX_WIDTH];
   logic [PIX_W-1:0] window_px [6];
   int unsigned row_pos = 0;
   int unsigned col_pos = 0;

   // Beats still owed by the filter, oldest first.
   lss_result_type pending_results [$];

   // Run bookkeeping.
   int idle_pct = 0;
   bit long_hold_req = 1'b0;
   int cycle_count = 0;
   int pixels_sent = 0;
   int beats_seen = 0;
   int border_beats = 0;
   int sharpened_beats = 0;
   int reg_writes = 0;
   int mismatch_count = 0;

   laplacian_sharpen_3x3 DUT (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pixel     (req_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_value (rsp_out_value),
      .rsp_is_border (rsp_is_border),
      .rsp_last      (rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // A width of zero acts as one, and anything past the line store acts as its size.
   function automatic int unsigned effective_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
      return cfg_width;
   endfunction

   function automatic int unsigned effective_height();
      return (cfg_height == 0) ? 1 : cfg_height;
   endfunction

   // Mostly random pixels, with the extremes showing up often.
   function automatic logic [PIX_W-1:0] random_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Advance the predicted filter by one accepted pixel and queue its beats.
   task automatic sharpen_pixel(input logic [PIX_W-1:0] pix);
      int unsigned w, h, r, c;
      int center, nsum, sharp;
      logic [PIX_W-1:0] top, mid;
      bit on_border, has_inner;
      lss_result_type res;
      w = effective_width();
      h = effective_height();
      // A size change may leave the position outside the frame.
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      r = row_pos;
      c = col_pos;
      top = store_two_up[c];
      mid = store_one_up[c];
      on_border = (r == 0) || (c == 0) || (r == h - 1) || (c == w - 1);
      has_inner = (r >= 2) && (c >= 2);
      // The border copy of the arriving pixel comes before the sharpened beat.
      if (on_border) begin
         res.row = ROW_W'(r);
         res.col = COL_W'(c);
         res.value = VAL_W'(pix);
         res.is_border = 1'b1;
         res.last = !has_inner;
         pending_results.push_back(res);
      end
      if (has_inner) begin
         center = int'(window_px[4]);
         nsum = int'(window_px[0]) + int'(window_px[1]) + int'(window_px[2])
              + int'(window_px[3]) + int'(window_px[5])
              + int'(top) + int'(mid) + int'(pix);
         sharp = center - (nsum - 8 * center) / 2;
         res.row = ROW_W'(r - 1);
         res.col = COL_W'(c - 1);
         res.value = VAL_W'(sharp);
         res.is_border = 1'b0;
         res.last = 1'b1;
         pending_results.push_back(res);
      end
      // Shift the window one column and update both line stores.
      window_px[0] = window_px[3];
      window_px[1] = window_px[4];
      window_px[2] = window_px[5];
      window_px[3] = top;
      window_px[4] = mid;
      window_px[5] = pix;
      store_two_up[c] = mid;
      store_one_up[c] = pix;
      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   // Offer one pixel beat, with an optional idle burst first. Valid stays high
   // after the beat so back-to-back pixels go without a gap.
   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      int gap;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= pix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sharpen_pixel(pix);
      pixels_sent++;
   endtask

   task automatic csr_write(input lss_csr_index_type idx, input logic [CSR_D_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_FRAME_WIDTH) cfg_width = 32'(data[FW_W-1:0]);
      else cfg_height = 32'(data[FH_W-1:0]);
      reg_writes++;
   endtask

   // Stop the input, let every owed beat out, then write both size registers.
   task automatic apply_frame_size(input int unsigned width_word,
                                   input int unsigned height_word);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      // Pixels that yield no beat may still be in flight.
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(CSR_FRAME_WIDTH, CSR_D_W'(width_word));
      csr_write(CSR_FRAME_HEIGHT, CSR_D_W'(height_word));
      csr_valid <= 1'b0;
   endtask

   // Reset sizes: three rows of a 64x64 frame. This fills both line stores in
   // the first 64 columns; the next size change cuts the height to the current
   // row index so the position wraps to the top of a new frame.
   task automatic test_reset_sizes();
      idle_pct = 20;
      repeat (192) send_pixel(random_pixel());
   endtask

   // Widest frame: the width word has every bit set, which acts as the full
   // line store. Only the start of the top row is sent.
   task automatic test_widest_frame();
      apply_frame_size('1, 3);
      idle_pct = 10;
      repeat (80) send_pixel(random_pixel());
   endtask

   // Tiny frames; those with fewer than three rows or columns are all border.
   task automatic test_small_frames();
      int sizes [7][3];
      sizes = '{'{0, 0, 3}, '{1, 4, 4}, '{2, 2, 4}, '{2, 3, 6}, '{3, 2, 6},
                '{3, 3, 9}, '{4, 5, 20}};
      idle_pct = 30;
      foreach (sizes[i]) begin
         apply_frame_size(sizes[i][0], sizes[i][1]);
         repeat (sizes[i][2]) send_pixel(random_pixel());
      end
   endtask

   // 3x3 frames with one interior pixel: largest and smallest sharpened
   // values, and odd differences that round toward zero both ways.
   task automatic test_value_extremes();
      logic [PIX_W-1:0] grid [5][9];
      grid = '{'{255, 255, 255, 255, 0, 255, 255, 255, 255},
               '{0, 0, 0, 0, 255, 0, 0, 0, 0},
               '{7, 0, 0, 0, 1, 0, 0, 0, 0},
               '{0, 0, 3, 0, 0, 0, 0, 0, 0},
               '{0, 0, 0, 0, 2, 0, 0, 0, 17}};
      apply_frame_size(3, 3);
      idle_pct = 0;
      foreach (grid[f, p]) send_pixel(grid[f][p]);
   endtask

   // Tallest frame with a zero width, which acts as one column; only the top
   // rows are sent.
   task automatic test_tallest_frame();
      apply_frame_size(0, 4095);
      idle_pct = 5;
      repeat (60) send_pixel(random_pixel());
   endtask

   // Size changes while the position sits inside a frame.
   task automatic test_midframe_resize();
      idle_pct = 15;
      apply_frame_size(8, 8);
      repeat (27) send_pixel(random_pixel());
      // Column now past the width: wraps to the next row.
      apply_frame_size(3, 8);
      repeat (10) send_pixel(random_pixel());
      // Row now past the height: wraps to the top.
      apply_frame_size(8, 2);
      repeat (20) send_pixel(random_pixel());
      apply_frame_size(5, 5);
      repeat (25) send_pixel(random_pixel());
   endtask

   // The output stalls for a long stretch while pixels keep coming, so the
   // filter fills up and pushes back on its input.
   task automatic test_output_stall();
      apply_frame_size(10, 10);
      idle_pct = 0;
      long_hold_req = 1'b1;
      repeat (100) send_pixel(random_pixel());
   endtask

   // Random sizes and random pixel runs; most runs are whole frames, the rest
   // stop partway so the next size change lands inside a frame. Widths stay
   // within the columns that earlier frames have filled in both line stores.
   task automatic test_random_frames(input int target, input bit allow_idle);
      int sent, run_len;
      int unsigned span;
      int unsigned width_word, height_word;
      sent = 0;
      while (sent < target) begin
         case ($urandom_range(0, 19))
            0: width_word = 0;
            1: width_word = 64;
            2: width_word = $urandom_range(0, 64);
            3, 4, 5, 6: width_word = $urandom_range(13, 40);
            default: width_word = $urandom_range(1, 12);
         endcase
         case ($urandom_range(0, 19))
            0: height_word = 0;
            1: height_word = 4095;
            2: height_word = $urandom_range(0, 4095);
            default: height_word = $urandom_range(1, 10);
         endcase
         apply_frame_size(width_word, height_word);
         if (!allow_idle) idle_pct = 0;
         else case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 15;
            default: idle_pct = 40;
         endcase
         span = effective_width() * effective_height();
         if (span <= 160 && $urandom_range(0, 4) != 0)
            run_len = span * $urandom_range(1, 2);
         else
            run_len = $urandom_range(1, 160);
         repeat (run_len) send_pixel(random_pixel());
         sent += run_len;
      end
   endtask

   // Output side: random idle bursts, or one long hold when a test asks.
   initial begin : output_side
      int burst;
      @(posedge clock);
      forever begin
         if (long_hold_req) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            long_hold_req = 1'b0;
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_ready <= 1'b0;
            burst = $urandom_range(1, 5);
            repeat (burst) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Compare each result beat with the oldest owed beat.
   always @(posedge clock) begin : check_beats
      lss_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_seen++;
         if (rsp_is_border) border_beats++;
         else sharpened_beats++;
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected beat: row %0d col %0d value %0d border %0b last %0b",
                        rsp_out_row, rsp_out_col, rsp_out_value, rsp_is_border, rsp_last);
         end else begin
            want = pending_results.pop_front();
            if (rsp_out_row !== want.row || rsp_out_col !== want.col ||
                rsp_out_value !== want.value || rsp_is_border !== want.is_border ||
                rsp_last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("beat %0d expected: row %0d col %0d value %0d border %0b last %0b",
                           beats_seen, want.row, want.col, want.value, want.is_border,
                           want.last);
                  $display("beat %0d actual:   row %0d col %0d value %0d border %0b last %0b",
                           beats_seen, rsp_out_row, rsp_out_col, rsp_out_value,
                           rsp_is_border, rsp_last);
               end
            end
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles with %0d beats owed", cycle_count,
                  pending_results.size());
         $display("laplacian_sharpen_3x3: mismatch");
         $finish;
      end
   end

   initial begin : run_tests
      foreach (store_one_up[i]) begin
         store_one_up[i] = '0;
         store_two_up[i] = '0;
      end
      foreach (window_px[i]) window_px[i] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_sizes();
      test_widest_frame();
      test_small_frames();
      test_value_extremes();
      test_tallest_frame();
      test_midframe_resize();
      test_output_stall();
      test_random_frames(380, 1'b1);
      test_random_frames(80, 1'b0);

      // Let the last beats out, then watch a little longer for strays.
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_results.size() != 0)
         $display("%0d beats never arrived", pending_results.size());
      $display("Streamed %0d pixels through %0d size register writes in %0d cycles.",
               pixels_sent, reg_writes, cycle_count);
      $display("Checked %0d result beats: %0d border copies and %0d sharpened pixels.",
               beats_seen, border_beats, sharpened_beats);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("laplacian_sharpen_3x3: match");
      else
         $display("laplacian_sharpen_3x3: mismatch");
      $finish;
   end

endmodule
